// ===== sv/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

	localparam int MAX_DIM = 64;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int ROW_W = 6;
	localparam int SIZE_W = 7;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic signed [DATA_W-1:0] value;
	} imm_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic [ROW_W-1:0] out_row;
		logic [ROW_W-1:0] out_col;
	} imm_out_t;

	typedef struct packed {
		logic clear;
		logic en;
	} imm_mac_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE = 4'b1000
	} imm_state_t;

endpackage

`default_nettype wire

// ===== sv/imm_ram.sv =====
`default_nettype none

module imm_ram
	import imm_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic we,
	input wire logic [ADDR_W-1:0] addr,
	input wire logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [MAX_DIM * MAX_DIM];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/imm_mac.sv =====
`default_nettype none

module imm_mac
	import imm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire imm_mac_ctl_t ctl,
	input wire logic [DATA_W-1:0] a,
	input wire logic [DATA_W-1:0] b,
	output logic [DATA_W-1:0] acc,
	output logic busy
);

	logic [DATA_W-1:0] prod_s2;
	logic mul_v_s2;
	logic [DATA_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else begin
			mul_v_s2 <= ctl.en & ~ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= DATA_W'(a * b);
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign acc = acc_q;
	assign busy = mul_v_s2;

endmodule

`default_nettype wire

// ===== sv/integer_matrix_multiply_top.sv =====
// Channel  Direction  Signals                    Beat
// in       input      in_valid, in_stall, in_data   one load or query command
// out      output     out_valid, out_stall, out_data one product entry
// cfg      input      cfg_we, cfg_data              size in use, taken on cfg_we
//
// A load beat writes one entry of the A or B memory.
// A query sums n products of A row and B column entries, where n is the size in use
// capped at the maximum dimension; one memory read and one multiply-accumulate per cycle.
// A query with size zero or an index beyond the store goes straight to the done state.
// Reset is asynchronous and clears control state only; matrix memories are not cleared.
// Input stalls until a query's result is registered; a held result does not block loads.
`default_nettype none

module integer_matrix_multiply_top
	import imm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire imm_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output imm_out_t out_data,
	input wire logic cfg_we,
	input wire logic [SIZE_W-1:0] cfg_data
);

	imm_state_t state_q;
	logic [SIZE_W-1:0] size_q;
	logic [ROW_W-1:0] r_q;
	logic [ROW_W-1:0] c_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] k_q;
	logic rd_v_s1;
	logic out_valid_q;
	imm_out_t out_q;

	logic in_beat;
	logic in_range;
	logic a_we;
	logic b_we;
	logic rd_en;
	logic [CNT_W-1:0] n_eff;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] a_addr;
	logic [ADDR_W-1:0] b_addr;
	logic [DATA_W-1:0] a_rdata;
	logic [DATA_W-1:0] b_rdata;
	logic [DATA_W-1:0] acc;
	logic mac_busy;
	logic load_out;
	logic query_go;
	imm_mac_ctl_t mac_ctl;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat = in_valid & ~in_stall;
	assign in_range = (32'(in_data.row) < MAX_DIM) && (32'(in_data.col) < MAX_DIM);
	assign a_we = in_beat && (in_data.cmd == CMD_WRITE_A) && in_range;
	assign b_we = in_beat && (in_data.cmd == CMD_WRITE_B) && in_range;
	assign query_go = in_beat && (in_data.cmd == CMD_QUERY);
	assign rd_en = (state_q == ST_RUN);
	assign n_eff = (32'(size_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(size_q);

	assign wr_addr = (ADDR_W'(in_data.row) << IDX_W) | ADDR_W'(in_data.col);
	assign a_addr = rd_en ? ((ADDR_W'(r_q) << IDX_W) | ADDR_W'(k_q)) : wr_addr;
	assign b_addr = rd_en ? ((ADDR_W'(k_q) << IDX_W) | ADDR_W'(c_q)) : wr_addr;

	assign mac_ctl.clear = query_go;
	assign mac_ctl.en = rd_v_s1;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	imm_ram u_ram_a (
		.clk (clk),
		.en (a_we | rd_en),
		.we (a_we),
		.addr (a_addr),
		.wdata (in_data.value),
		.rdata (a_rdata)
	);

	imm_ram u_ram_b (
		.clk (clk),
		.en (b_we | rd_en),
		.we (b_we),
		.addr (b_addr),
		.wdata (in_data.value),
		.rdata (b_rdata)
	);

	imm_mac u_mac (
		.clk (clk),
		.arst_n (arst_n),
		.ctl (mac_ctl),
		.a (a_rdata),
		.b (b_rdata),
		.acc (acc),
		.busy (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q <= SIZE_RESET;
			k_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			rd_v_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						k_q <= '0;
						if (in_range && (n_eff != '0)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + 1'b1;
					if ((CNT_W'(k_q) + 1'b1) == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			r_q <= in_data.row;
			c_q <= in_data.col;
			n_q <= n_eff;
		end
		if (load_out) begin
			out_q.product <= acc;
			out_q.out_row <= r_q;
			out_q.out_col <= c_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> (state_q == ST_IDLE))
		else $error("Matrix load while a query is in flight.");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CNT_W'(k_q) < n_q))
		else $error("Inner index ran past the size in use.");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!rd_v_s1 && !mac_busy))
		else $error("Result taken before the accumulator settled.");

	a_read_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("Read data arrived outside a query.");
`endif

endmodule

`default_nettype wire

// ===== dv/integer_matrix_multiply_top_tb.sv =====
`timescale 1ns / 100ps

module integer_matrix_multiply_top_tb;
	import imm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEGMENT_ACTIONS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_stall;
	imm_in_t in_data;
	logic out_valid;
	logic out_stall;
	imm_out_t out_data;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	logic [DATA_W-1:0] left_entries [MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] right_entries [MAX_DIM*MAX_DIM];
	bit left_known [MAX_DIM*MAX_DIM];
	bit right_known [MAX_DIM*MAX_DIM];
	logic [SIZE_W-1:0] size_now = SIZE_RESET;
	imm_out_t expected_products [$];
	imm_out_t want_beat;
	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	integer_matrix_multiply_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected product beat, actual %h", $time, out_data);
				error_count++;
			end else begin
				want_beat = expected_products.pop_front();
				if (out_data.product !== want_beat.product) begin
					$display("%0t: product expected %h actual %h", $time,
						want_beat.product, out_data.product);
					error_count++;
				end
				if (out_data.out_row !== want_beat.out_row) begin
					$display("%0t: out_row expected %0d actual %0d", $time,
						want_beat.out_row, out_data.out_row);
					error_count++;
				end
				if (out_data.out_col !== want_beat.out_col) begin
					$display("%0t: out_col expected %0d actual %0d", $time,
						want_beat.out_col, out_data.out_col);
					error_count++;
				end
			end
		end
	end

	function automatic int depth_in_use();
		return (size_now > MAX_DIM) ? MAX_DIM : int'(size_now);
	endfunction

	function automatic logic [DATA_W-1:0] dot_product(input int r, input int c);
		logic [DATA_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < depth_in_use(); k++)
			acc = acc + left_entries[r*MAX_DIM + k] * right_entries[k*MAX_DIM + c];
		return acc;
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return WORD_MIN;
			2: return WORD_MAX;
			3: return WORD_ONES;
			4: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic imm_in_t make_beat(input logic [CMD_W-1:0] cmd, input int r,
		input int c, input logic [DATA_W-1:0] v);
		imm_in_t b;
		b.cmd = cmd;
		b.row = r[ROW_W-1:0];
		b.col = c[ROW_W-1:0];
		b.value = v;
		return b;
	endfunction

	task automatic send_beat(input imm_in_t beat);
		imm_out_t answer;
		int idx;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do
			@(posedge clk);
		while (in_stall);
		idx = beat.row * MAX_DIM + beat.col;
		case (beat.cmd)
			CMD_WRITE_A: begin
				left_entries[idx] = beat.value;
				left_known[idx] = 1'b1;
			end
			CMD_WRITE_B: begin
				right_entries[idx] = beat.value;
				right_known[idx] = 1'b1;
			end
			CMD_QUERY: begin
				answer.product = dot_product(beat.row, beat.col);
				answer.out_row = beat.row;
				answer.out_col = beat.col;
				expected_products.push_back(answer);
			end
			default: ;
		endcase
	endtask

	// Writes every entry the dot product will read that has not been written yet, then sends the query.
	task automatic run_query(input int r, input int c);
		for (int k = 0; k < depth_in_use(); k++) begin
			if (!left_known[r*MAX_DIM + k])
				send_beat(make_beat(CMD_WRITE_A, r, k, rand_word()));
			if (!right_known[k*MAX_DIM + c])
				send_beat(make_beat(CMD_WRITE_B, k, c, rand_word()));
		end
		send_beat(make_beat(CMD_QUERY, r, c, rand_word()));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] n);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_now = n;
	endtask

	task automatic test_reset_size();
		for (int k = 0; k < MAX_DIM; k++) begin
			send_beat(make_beat(CMD_WRITE_A, 0, k, WORD_MIN));
			send_beat(make_beat(CMD_WRITE_A, MAX_DIM - 1, k, WORD_MAX));
			send_beat(make_beat(CMD_WRITE_B, k, 0, WORD_MIN));
			send_beat(make_beat(CMD_WRITE_B, k, MAX_DIM - 1, WORD_ONES));
		end
		send_beat(make_beat(CMD_QUERY, 0, 0, '0));
		send_beat(make_beat(CMD_QUERY, MAX_DIM - 1, MAX_DIM - 1, WORD_ONES));
		send_beat(make_beat(CMD_QUERY, 0, MAX_DIM - 1, WORD_MIN));
		send_beat(make_beat(CMD_QUERY, MAX_DIM - 1, 0, WORD_MAX));
	endtask

	task automatic test_size_edges();
		set_size(7'd1);
		send_beat(make_beat(CMD_WRITE_A, 5, 0, WORD_MAX));
		send_beat(make_beat(CMD_WRITE_B, 0, 9, WORD_MAX));
		send_beat(make_beat(CMD_QUERY, 5, 9, '0));
		// Row and column beyond the size in use are still answered.
		run_query(40, MAX_DIM - 1);
		set_size(7'd0);
		send_beat(make_beat(CMD_QUERY, 17, 3, WORD_ONES));
		set_size(7'd127);
		send_beat(make_beat(CMD_QUERY, 0, 0, '0));
		send_beat(make_beat(CMD_QUERY, MAX_DIM - 1, MAX_DIM - 1, '0));
		set_size(7'd2);
		run_query(MAX_DIM - 1, 0);
	endtask

	task automatic test_ignored_items();
		send_beat(make_beat(CMD_WRITE_A, 0, 0, 32'd3));
		send_beat(make_beat(CMD_UNUSED, 0, 0, WORD_MAX));
		send_beat(make_beat(CMD_UNUSED, MAX_DIM - 1, MAX_DIM - 1, WORD_ONES));
		send_beat(make_beat(CMD_QUERY, 0, 0, WORD_ONES));
		send_beat(make_beat(CMD_UNUSED, 21, 42, '0));
		run_query(0, 1);
	endtask

	task automatic random_step();
		int kind;
		int n;
		int r;
		int c;
		logic [CMD_W-1:0] cmd;
		kind = $urandom_range(99);
		n = depth_in_use();
		if (kind < 45) begin
			if (n > 16) begin
				r = $urandom_range(1) ? $urandom_range(1) : MAX_DIM - 1 - $urandom_range(1);
				c = $urandom_range(1) ? $urandom_range(1) : MAX_DIM - 1 - $urandom_range(1);
			end else begin
				r = $urandom_range(MAX_DIM - 1);
				c = $urandom_range(MAX_DIM - 1);
			end
			run_query(r, c);
		end else if (kind < 92) begin
			cmd = $urandom_range(1) ? CMD_WRITE_A : CMD_WRITE_B;
			if ($urandom_range(1) && n > 0) begin
				r = $urandom_range(n - 1);
				c = $urandom_range(n - 1);
			end else begin
				r = $urandom_range(MAX_DIM - 1);
				c = $urandom_range(MAX_DIM - 1);
			end
			send_beat(make_beat(cmd, r, c, rand_word()));
		end else begin
			send_beat(make_beat(CMD_UNUSED, $urandom_range(MAX_DIM - 1),
				$urandom_range(MAX_DIM - 1), rand_word()));
		end
	endtask

	task automatic test_random_traffic();
		logic [SIZE_W-1:0] n;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 69;
				end
				default: begin
					idle_pct = 16;
					stall_pct = 16;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				case ($urandom_range(9))
					0: n = 7'd0;
					1: n = 7'd64;
					2: n = 7'd127;
					3: n = SIZE_W'($urandom_range(126, 65));
					default: n = SIZE_W'($urandom_range(8, 1));
				endcase
				set_size(n);
				for (int i = 0; i < SEGMENT_ACTIONS; i++)
					random_step();
			end
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		out_stall <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_size_edges();
		test_ignored_items();
		test_random_traffic();
		drain_results();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/imm_pkg.sv
sv/imm_ram.sv
sv/imm_mac.sv
sv/integer_matrix_multiply_top.sv
dv/integer_matrix_multiply_top_tb.sv
